[rtl/npis_pkg.sv]
// ----------------------------------------------------------------------------
// npis_pkg: shared types and constants
// Task record, command codes and sequencer states of the interrupt scheduler.
// ----------------------------------------------------------------------------
package npis_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] left;
   } task_type;

   typedef struct packed {
      logic        cpu_idle;
      logic [7:0]  run_id;
      logic [7:0]  run_prio;
      logic [15:0] run_left;
      logic        rec_valid;
      logic [7:0]  rec_id;
      logic [7:0]  rec_prio;
      logic [15:0] rec_ticks;
      logic        dropped;
   } rsp_type;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  task_id;
      logic [7:0]  task_prio;
      logic [15:0] run_ticks;
   } req_type;

   // IDLE: wait for a request; RD: stack top and queue head/tail reads;
   // DECIDE: update the running task; INS_RD/INS_CMP: walk the queue from
   // the tail, shifting entries up; POP_RD/POP_WR: shift the queue down; RESP
   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_DECIDE, ST_INS_RD, ST_INS_CMP, ST_POP_RD, ST_POP_WR, ST_RESP
   } state_type;

endpackage

[rtl/npis_if.sv]
// ----------------------------------------------------------------------------
// npis_if: valid/ready channel
// Carries one payload of a given type between a source and a sink.
// ----------------------------------------------------------------------------
interface npis_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/nested_priority_interrupt_scheduler.sv]
// ----------------------------------------------------------------------------
// nested_priority_interrupt_scheduler
// Preemptive priority scheduler: running task, preemption stack, sorted queue.
// ----------------------------------------------------------------------------
// After the request transfer the block passes through RD and DECIDE; a sorted
// insert into a non-empty queue then walks from the tail (INS_CMP/INS_RD,
// shifting entries up) and a pop shifts the rest down (POP_RD/POP_WR) before
// the result is offered in RESP. One item at a time; the next request is
// taken the cycle after the result transfer.
// Reset (synchronous) makes the block idle with empty stack and queue.
module nested_priority_interrupt_scheduler #(
   parameter int STACK_DEPTH = npis_pkg::STACK_DEPTH_DEF,
   parameter int QUEUE_DEPTH = npis_pkg::QUEUE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   npis_if.sink   req_ch,
   npis_if.source rsp_ch
);
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SCW = $clog2(STACK_DEPTH + 1);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   npis_pkg::state_type state_ff, state_in;
   npis_pkg::req_type   req_ff, req_in;
   npis_pkg::rsp_type   rsp_ff, rsp_in;
   npis_pkg::task_type  cur_ff, cur_in;
   logic                idle_ff, idle_in;
   logic [15:0]         seg_ff, seg_in;
   logic [SCW-1:0]      scnt_ff, scnt_in;
   logic [QCW-1:0]      qcnt_ff, qcnt_in;
   logic [QCW-1:0]      pos_ff, pos_in;     // walking index
   npis_pkg::task_type  stk_top_ff, qrd_ff;

   npis_pkg::task_type  stack_mem [STACK_DEPTH];
   npis_pkg::task_type  queue_mem [QUEUE_DEPTH];

   // memory control
   logic               s_we, q_we;
   logic [SAW-1:0]     s_wa, s_ra;
   logic [QAW-1:0]     q_wa, q_ra;
   npis_pkg::task_type s_wd, q_wd;

   npis_pkg::task_type arr_task;
   assign arr_task = '{id: req_ff.task_id, prio: req_ff.task_prio, left: req_ff.run_ticks};

   assign req_ch.ready = (state_ff == npis_pkg::ST_IDLE);
   assign rsp_ch.valid = (state_ff == npis_pkg::ST_RESP);
   assign rsp_ch.data  = rsp_ff;

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (s_we) stack_mem[s_wa] <= s_wd;
      stk_top_ff <= stack_mem[s_ra];
   end
   always_ff @(posedge clock) begin
      if (q_we) queue_mem[q_wa] <= q_wd;
      qrd_ff <= queue_mem[q_ra];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npis_pkg::ST_IDLE;
         idle_ff  <= 1'b1;
         cur_ff   <= '0;
         seg_ff   <= '0;
         scnt_ff  <= '0;
         qcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idle_ff  <= idle_in;
         cur_ff   <= cur_in;
         seg_ff   <= seg_in;
         scnt_ff  <= scnt_in;
         qcnt_ff  <= qcnt_in;
      end
   end
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      pos_ff <= pos_in;
   end

   // next state
   logic        done;
   logic        take_stack;
   assign done = (cur_ff.left <= 16'd1);
   assign take_stack = (scnt_ff != '0) &&
                       ((qcnt_ff == '0) || (stk_top_ff.prio <= qrd_ff.prio));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npis_pkg::ST_IDLE:    if (req_ch.valid) state_in = npis_pkg::ST_RD;
         npis_pkg::ST_RD:      state_in = npis_pkg::ST_DECIDE;
         npis_pkg::ST_DECIDE: begin
            state_in = npis_pkg::ST_RESP;
            if (req_ff.cmd == npis_pkg::CMD_ARRIVE) begin
               if (!idle_ff && !(req_ff.task_prio < cur_ff.prio) &&
                   (qcnt_ff < QCW'(QUEUE_DEPTH)))
                  state_in = (qcnt_ff == '0) ? npis_pkg::ST_RESP : npis_pkg::ST_INS_CMP;
            end else if (!idle_ff && done && !take_stack && (qcnt_ff > QCW'(1))) begin
               state_in = npis_pkg::ST_POP_RD;
            end
         end
         npis_pkg::ST_INS_RD:  state_in = npis_pkg::ST_INS_CMP;
         npis_pkg::ST_INS_CMP: begin
            if (qrd_ff.prio <= req_ff.task_prio || pos_ff == '0)
               state_in = npis_pkg::ST_RESP;
            else
               state_in = npis_pkg::ST_INS_RD;
         end
         npis_pkg::ST_POP_RD:  state_in = npis_pkg::ST_POP_WR;
         npis_pkg::ST_POP_WR:
            state_in = (pos_ff == qcnt_ff) ? npis_pkg::ST_RESP : npis_pkg::ST_POP_RD;
         npis_pkg::ST_RESP:    if (rsp_ch.ready) state_in = npis_pkg::ST_IDLE;
         default:              state_in = npis_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_in  = req_ff;
      rsp_in  = rsp_ff;
      cur_in  = cur_ff;
      idle_in = idle_ff;
      seg_in  = seg_ff;
      scnt_in = scnt_ff;
      qcnt_in = qcnt_ff;
      pos_in  = pos_ff;
      s_we = 1'b0; s_wa = '0; s_wd = cur_ff;
      s_ra = SAW'(scnt_ff - SCW'(1));
      q_we = 1'b0; q_wa = '0; q_wd = arr_task;
      q_ra = '0;
      case (state_ff)
         npis_pkg::ST_IDLE: begin
            if (req_ch.valid) req_in = req_ch.data;
            rsp_in = '0;
         end
         npis_pkg::ST_RD: begin
            // stack top and queue head (or queue tail for insert)
            q_ra = (req_ff.cmd == npis_pkg::CMD_ARRIVE) ?
                   QAW'(qcnt_ff - QCW'(1)) : '0;
         end
         npis_pkg::ST_DECIDE: begin
            // keep the queue tail in the read register for the insert walk
            if (req_ff.cmd == npis_pkg::CMD_ARRIVE) q_ra = QAW'(qcnt_ff - QCW'(1));
            if (req_ff.cmd == npis_pkg::CMD_ARRIVE) begin
               if (idle_ff) begin
                  cur_in = arr_task; idle_in = 1'b0; seg_in = '0;
               end else if (req_ff.task_prio < cur_ff.prio) begin
                  if (seg_ff != '0) begin
                     rsp_in.rec_valid = 1'b1;
                     rsp_in.rec_id    = cur_ff.id;
                     rsp_in.rec_prio  = cur_ff.prio;
                     rsp_in.rec_ticks = seg_ff;
                  end
                  seg_in = '0;
                  if (scnt_ff < SCW'(STACK_DEPTH)) begin
                     s_we = 1'b1; s_wa = SAW'(scnt_ff);
                     scnt_in = scnt_ff + SCW'(1);
                  end else begin
                     rsp_in.dropped = 1'b1;
                  end
                  cur_in = arr_task;
               end else if (qcnt_ff < QCW'(QUEUE_DEPTH)) begin
                  qcnt_in = qcnt_ff + QCW'(1);
                  pos_in  = qcnt_ff;   // free slot; qrd holds entry pos-1
                  if (qcnt_ff == '0) begin
                     q_we = 1'b1; q_wa = '0;
                  end
               end else begin
                  rsp_in.dropped = 1'b1;
               end
            end else if (!idle_ff) begin
               cur_in.left = done ? 16'd0 : cur_ff.left - 16'd1;
               if (done) begin
                  rsp_in.rec_valid = 1'b1;
                  rsp_in.rec_id    = cur_ff.id;
                  rsp_in.rec_prio  = cur_ff.prio;
                  rsp_in.rec_ticks = (seg_ff == 16'hFFFF) ? seg_ff : seg_ff + 16'd1;
                  seg_in = '0;
                  if (take_stack) begin
                     cur_in  = stk_top_ff;
                     scnt_in = scnt_ff - SCW'(1);
                  end else if (qcnt_ff != '0) begin
                     cur_in  = qrd_ff;
                     qcnt_in = qcnt_ff - QCW'(1);
                     pos_in  = QCW'(1);
                  end else begin
                     idle_in = 1'b1;
                  end
               end else if (seg_ff != 16'hFFFF) begin
                  seg_in = seg_ff + 16'd1;
               end
            end
         end
         npis_pkg::ST_INS_RD: begin
            q_ra = QAW'(pos_ff - QCW'(1));
         end
         npis_pkg::ST_INS_CMP: begin
            // qrd holds entry pos-1: shift it up or place the arrival at pos
            q_we = 1'b1; q_wa = QAW'(pos_ff);
            if (qrd_ff.prio <= req_ff.task_prio) begin
               q_wd = arr_task;
            end else begin
               q_wd = qrd_ff;
               if (pos_ff == QCW'(1)) begin
                  // last shift; arrival lands at the head next
                  pos_in = '0;
               end else begin
                  pos_in = pos_ff - QCW'(1);
               end
            end
            if (pos_ff == '0) q_wd = arr_task;
         end
         npis_pkg::ST_POP_RD: begin
            q_ra = QAW'(pos_ff);
         end
         npis_pkg::ST_POP_WR: begin
            q_we = 1'b1; q_wa = QAW'(pos_ff - QCW'(1)); q_wd = qrd_ff;
            pos_in = pos_ff + QCW'(1);
         end
         default: ;
      endcase
      // output view of running task
      if (state_ff == npis_pkg::ST_DECIDE) begin
         rsp_in.cpu_idle = idle_in;
         rsp_in.run_id   = idle_in ? 8'd0  : cur_in.id;
         rsp_in.run_prio = idle_in ? 8'd0  : cur_in.prio;
         rsp_in.run_left = idle_in ? 16'd0 : cur_in.left;
      end
   end

   // pos==0 after last shift: INS_CMP again writes the arrival at the head
   // (qrd compare ignored there). Handled by the pos_ff=='0 override above.

   a_cnt_stack: assert property (@(posedge clock) disable iff (reset)
      scnt_ff <= SCW'(STACK_DEPTH)) else $error("stack count overflow");
   a_cnt_queue: assert property (@(posedge clock) disable iff (reset)
      qcnt_ff <= QCW'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == npis_pkg::ST_IDLE && idle_ff) |-> (scnt_ff == '0 && qcnt_ff == '0))
      else $error("idle with pending tasks");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid && $stable(rsp_ff)))
      else $error("result changed while stalled");
endmodule

[tb/npis_check.sv]
// ----------------------------------------------------------------------------
// npis_check: scheduler result checker
// Watches request and response transfers, predicts each response from its own
// copy of the running task, preemption stack and wait queue, and compares.
// ----------------------------------------------------------------------------
module npis_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  npis_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  npis_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending_count
);

   // predicted scheduler state
   logic               sched_idle;
   npis_pkg::task_type run_task;
   logic [15:0]        seg_len;
   npis_pkg::task_type stack_mem[$];
   npis_pkg::task_type wait_mem[$];
   npis_pkg::rsp_type  expected_rsp[$];

   function automatic void mark_segment(ref npis_pkg::rsp_type r);
      r.rec_valid = 1'b1;
      r.rec_id    = run_task.id;
      r.rec_prio  = run_task.prio;
      r.rec_ticks = seg_len;
   endfunction

   // advance the predicted state by one request and queue the response
   task automatic schedule_event(input npis_pkg::req_type q);
      npis_pkg::rsp_type  r;
      npis_pkg::task_type t;
      int                 pos;
      logic               done;
      r = '0;
      t.id   = q.task_id;
      t.prio = q.task_prio;
      t.left = q.run_ticks;
      if (q.cmd == npis_pkg::CMD_ARRIVE) begin
         if (sched_idle) begin
            run_task   = t;
            sched_idle = 1'b0;
            seg_len    = '0;
         end else if (t.prio < run_task.prio) begin
            if (seg_len != 0) begin
               mark_segment(r);
               seg_len = '0;
            end
            if (stack_mem.size() < npis_pkg::STACK_DEPTH_DEF) stack_mem.push_back(run_task);
            else r.dropped = 1'b1;
            run_task = t;
         end else if (wait_mem.size() >= npis_pkg::QUEUE_DEPTH_DEF) begin
            r.dropped = 1'b1;
         end else begin
            // sorted insert, FIFO among equal priorities
            pos = 0;
            while (pos < wait_mem.size() && wait_mem[pos].prio <= t.prio) pos++;
            wait_mem.insert(pos, t);
         end
      end else if (!sched_idle) begin
         done = (run_task.left <= 1);
         run_task.left = done ? 16'd0 : run_task.left - 16'd1;
         if (seg_len != 16'hFFFF) seg_len++;
         if (done) begin
            mark_segment(r);
            seg_len    = '0;
            sched_idle = 1'b1;
            // stack top wins ties against the queue head
            if (stack_mem.size() > 0 && (wait_mem.size() == 0 ||
                stack_mem[$].prio <= wait_mem[0].prio)) begin
               run_task   = stack_mem.pop_back();
               sched_idle = 1'b0;
            end else if (wait_mem.size() > 0) begin
               run_task   = wait_mem.pop_front();
               sched_idle = 1'b0;
            end
         end
      end
      r.cpu_idle = sched_idle;
      if (!sched_idle) begin
         r.run_id   = run_task.id;
         r.run_prio = run_task.prio;
         r.run_left = run_task.left;
      end
      expected_rsp.push_back(r);
   endtask

   always @(posedge clock) begin
      npis_pkg::rsp_type e;
      if (reset) begin
         sched_idle = 1'b1;
         run_task   = '0;
         seg_len    = '0;
         stack_mem.delete();
         wait_mem.delete();
         expected_rsp.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) schedule_event(req_data);
         // compare the response transfer with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

[tb/nested_priority_interrupt_scheduler_test.sv]
// ----------------------------------------------------------------------------
// nested_priority_interrupt_scheduler_test: scheduler testbench
// Directed arrivals and ticks, then random nested arrival/tick traffic with
// bursty requests, random response stalls and one long response hold-off.
// ----------------------------------------------------------------------------
module nested_priority_interrupt_scheduler_test;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   logic hold_off = 1'b0;
   logic stim_done = 1'b0;

   npis_if #(.payload_type(npis_pkg::req_type)) req_ch ();
   npis_if #(.payload_type(npis_pkg::rsp_type)) rsp_ch ();

   nested_priority_interrupt_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   npis_check checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_data      (req_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_data      (rsp_ch.data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // drive one request and hold it until transferred
   task automatic send_event(input logic c, input logic [7:0] id,
                             input logic [7:0] pr, input logic [15:0] tk);
      npis_pkg::req_type q;
      q.cmd       = c;
      q.task_id   = id;
      q.task_prio = pr;
      q.run_ticks = tk;
      req_ch.valid <= 1'b1;
      req_ch.data  <= q;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_tick();
      send_event(npis_pkg::CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic send_arrival(input logic [7:0] pr, input logic [15:0] tk);
      send_event(npis_pkg::CMD_ARRIVE, 8'($urandom), pr, tk);
   endtask

   // receiver: random stalls, one long hold-off, stretches of full speed
   always @(posedge clock) begin
      if (hold_off) rsp_ch.ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 2) != 0);
   end

   initial begin
      int n, burst, k;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: tick while idle, extremes, zero run time, preemption
      send_tick();
      send_arrival(8'd255, 16'hFFFF);
      send_arrival(8'd255, 16'd0);
      send_tick();
      send_arrival(8'd0, 16'd0);
      send_tick();
      send_arrival(8'd254, 16'd1);
      send_arrival(8'd100, 16'd2);
      send_arrival(8'd100, 16'd0);
      send_tick();
      // fill the stack past its depth, then the queue past its depth
      for (k = 0; k < 18; k++) send_arrival(8'(100 - 5 * k), 16'd1);
      for (k = 0; k < 18; k++) send_arrival(8'd200, 16'(k));
      for (k = 0; k < 40; k++) send_tick();

      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clock);
            hold_off <= 1'b0;
         end
         for (k = 0; k < 20; k++)
            send_arrival(8'($urandom), 16'($urandom_range(0, 3)));
      join

      // random phase: bursts of nested arrivals and ticks, with gaps
      n = 0;
      while (n < 1200) begin
         burst = $urandom_range(1, 30);
         for (k = 0; k < burst; k++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: send_arrival(8'($urandom_range(0, 31)), 16'($urandom_range(0, 6)));
               3:       send_arrival(8'($urandom), 16'($urandom));
               default: send_tick();
            endcase
            n++;
         end
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(0, 12)) @(posedge clock);
      end
      // stop offering requests
      req_ch.valid <= 1'b0;
      stim_done <= 1'b1;
   end

   // verdict once all responses are in
   initial begin
      wait (stim_done);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[nested_priority_interrupt_scheduler.f]
rtl/npis_pkg.sv
rtl/npis_if.sv
rtl/nested_priority_interrupt_scheduler.sv
tb/npis_check.sv
tb/nested_priority_interrupt_scheduler_test.sv
